// ----- rtl/core/ilist_pkg.sv -----
// ----------------------------------------------------------------------------
// ilist_pkg
// shared types and constants for the indexed list engine
// ----------------------------------------------------------------------------
package ilist_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CMD_W         = 3;
  localparam int LIST_INDEX_W  = 10;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 11;

  // read taps are or-reduced in groups of this many cells
  localparam int GRP_SHIFT = 5;
  localparam int GRP_SIZE  = 1 << GRP_SHIFT;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_AT     = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [LIST_INDEX_W-1:0] pos;
    logic [VALUE_W-1:0]      value;
  } ilist_ctl_t;

endpackage

// ----- rtl/core/ilist_cell.sv -----
// ----------------------------------------------------------------------------
// ilist_cell
// one list slot: holds a value, shifts toward tail on insert, toward head on
// delete, and drives its value onto a read tap when addressed
// ----------------------------------------------------------------------------
module ilist_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                                   clk,
  input  ilist_pkg::ilist_ctl_t                  ctl,
  input  logic signed [ilist_pkg::VALUE_W-1:0]   left_value,
  input  logic signed [ilist_pkg::VALUE_W-1:0]   right_value,
  input  logic [ilist_pkg::LIST_INDEX_W-1:0]     rd_index,
  output logic signed [ilist_pkg::VALUE_W-1:0]   value,
  output logic signed [ilist_pkg::VALUE_W-1:0]   tap
);
  import ilist_pkg::*;

  localparam logic [LIST_INDEX_W-1:0] IDX = LIST_INDEX_W'(CELL_IDX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (IDX == ctl.pos) begin
        value <= ctl.value;
      end else if (IDX > ctl.pos) begin
        value <= left_value;
      end
    end else if (ctl.del && (IDX >= ctl.pos)) begin
      value <= right_value;
    end
  end

  assign tap = (rd_index == IDX) ? value : '0;

endmodule

// ----- rtl/core/ilist_chain.sv -----
// ----------------------------------------------------------------------------
// ilist_chain
// row of list cells plus a two-level registered read select
// ----------------------------------------------------------------------------
module ilist_chain #(
  parameter int DEPTH = ilist_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  ilist_pkg::ilist_ctl_t                  ctl,
  input  logic                                   rd_load,
  input  logic [ilist_pkg::LIST_INDEX_W-1:0]     rd_index,
  output logic signed [ilist_pkg::VALUE_W-1:0]   rd_data
);
  import ilist_pkg::*;

  localparam int NGRP   = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int NSLOT  = NGRP * GRP_SIZE;

  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic signed [VALUE_W-1:0] tap        [NSLOT];
  logic signed [VALUE_W-1:0] grp_or     [NGRP];
  logic signed [VALUE_W-1:0] grp_q      [2**GSEL_W];
  logic [LIST_INDEX_W-GRP_SHIFT-1:0] grp_full;
  logic [GSEL_W-1:0]                 gsel_q;

  for (genvar i = 0; i < NSLOT; i++) begin : g_cell
    if (i < DEPTH) begin : g_real
      logic signed [VALUE_W-1:0] left_v;
      logic signed [VALUE_W-1:0] right_v;
      if (i == 0) begin : g_head
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign right_v = cell_value[i];
      end else begin : g_mid_r
        assign right_v = cell_value[i+1];
      end
      ilist_cell #(.CELL_IDX(i)) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .left_value  (left_v),
        .right_value (right_v),
        .rd_index    (rd_index),
        .value       (cell_value[i]),
        .tap         (tap[i])
      );
    end else begin : g_pad
      assign tap[i] = '0;
    end
  end

  // first level: or of the taps inside each group
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        grp_or[g] = grp_or[g] | tap[g*GRP_SIZE + k];
      end
    end
  end

  assign grp_full = rd_index[LIST_INDEX_W-1:GRP_SHIFT];

  always_ff @(posedge clk) begin
    if (rd_load) begin
      for (int g = 0; g < 2**GSEL_W; g++) begin
        grp_q[g] <= (g < NGRP) ? grp_or[g] : '0;
      end
      gsel_q <= grp_full[GSEL_W-1:0];
    end
  end

  // second level: pick the addressed group
  assign rd_data = grp_q[gsel_q];

endmodule

// ----- rtl/core/indexed_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// ordered list of signed 32-bit words with positional insert, delete and read
// ----------------------------------------------------------------------------
// A command word is taken on a rising edge where start is high and busy is low.
// Every command yields exactly one result word, shown for one cycle with done
// high; the receiver cannot stall it, so it must take it in that cycle.
// Insert and delete commands need no wait: the list is a row of DEPTH
// cells that all shift in the same edge, so done follows in the cycle after
// acceptance and busy stays low (one command per cycle).
// For a read, the addressed cell is picked first inside its
// group of 32 cells and then among the groups, each level registered. busy is
// high for the one cycle between, and done follows with the second level's result.
// read_value is -1 for everything but a successful read. status: 0 done,
// 1 invalid position, 2 list full. entry_count is the count after the command.
// No clearing pass after reset: cells are only read below the count.
// ----------------------------------------------------------------------------
module indexed_list_engine_top #(
  parameter int DEPTH = ilist_pkg::DEPTH_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [ilist_pkg::CMD_W-1:0]               command,
  input  logic [ilist_pkg::LIST_INDEX_W-1:0]        list_index,
  input  logic signed [ilist_pkg::VALUE_W-1:0]      item_value,
  output logic                                      done,
  output logic signed [ilist_pkg::VALUE_W-1:0]      read_value,
  output logic [ilist_pkg::STATUS_W-1:0]            status,
  output logic [ilist_pkg::COUNT_OUT_W-1:0]         entry_count
);
  import ilist_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [COUNT_OUT_W-1:0] DEPTH_EXT = COUNT_OUT_W'(DEPTH);

  // list state
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;

  // pending read
  logic                   rd_ok;

  logic                   accept;
  logic                   is_read;
  logic [COUNT_OUT_W-1:0] cnt_ext;
  logic [COUNT_OUT_W-1:0] idx_ext;
  logic                   full;
  status_t                st;
  ilist_ctl_t             ctl;
  logic signed [VALUE_W-1:0] rd_data;

  assign accept  = start & ~busy;
  assign is_read = (cmd_t'(command) == CMD_READ);
  assign cnt_ext = COUNT_OUT_W'(count);
  assign idx_ext = COUNT_OUT_W'(list_index);
  assign full    = (cnt_ext == DEPTH_EXT);

  // command decode: shift control, status and next count
  always_comb begin
    ctl        = '0;
    ctl.value  = item_value;
    st         = ST_DONE;
    count_next = count;
    unique case (cmd_t'(command))
      CMD_READ: begin
        if (!(idx_ext < cnt_ext)) begin
          st = ST_BAD_POS;
        end
      end
      CMD_HEAD: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins    = accept;
          ctl.pos    = '0;
          count_next = count + 1'b1;
        end
      end
      CMD_TAIL: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins    = accept;
          ctl.pos    = cnt_ext[LIST_INDEX_W-1:0];
          count_next = count + 1'b1;
        end
      end
      CMD_AT: begin
        if (idx_ext > cnt_ext) begin
          st = ST_BAD_POS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ctl.ins    = accept;
          ctl.pos    = list_index;
          count_next = count + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (idx_ext < cnt_ext) begin
          ctl.del    = accept;
          ctl.pos    = list_index;
          count_next = count - 1'b1;
        end else begin
          st = ST_BAD_POS;
        end
      end
      default: begin
        st = ST_BAD_POS;
      end
    endcase
  end

  ilist_chain #(.DEPTH(DEPTH)) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .rd_load  (accept & is_read),
    .rd_index (list_index),
    .rd_data  (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      busy <= accept & is_read;
      done <= busy | (accept & ~is_read);
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok <= (st == ST_DONE);
    end
    if (busy) begin
      read_value  <= rd_ok ? rd_data : -32'sd1;
      status      <= rd_ok ? ST_DONE : ST_BAD_POS;
      entry_count <= cnt_ext;
    end else if (accept && !is_read) begin
      read_value  <= -32'sd1;
      status      <= st;
      entry_count <= COUNT_OUT_W'(count_next);
    end
  end

  // busy only ever covers the middle cycle of a read
  a_busy_after_read: assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(start && !busy && (command == CMD_READ)))
    else $error("busy without a read in flight");

  // count stays within the list depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= DEPTH_EXT)
    else $error("count beyond depth");

  // a non-read command is answered in the next cycle
  a_done_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command != CMD_READ)) |=> done)
    else $error("missing result word");

  // reported count matches the live count
  a_count_report: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count == cnt_ext))
    else $error("entry_count disagrees with count");

  // list full only reported at full depth
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> full)
    else $error("full status with room left");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the indexed list engine: commands go in from a
// queue through a start/busy driver, and every done word is compared
// field by field against a mirror of the list kept in the bench
// ----------------------------------------------------------------------------
module tb;
  import ilist_pkg::*;

  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int NUM_RANDOM     = 1280;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_EVERY    = 250;
  localparam int DRAIN_AT       = 200;
  localparam int QUIET_FIRST    = 500;
  localparam int QUIET_LAST     = 800;

  localparam logic signed [VALUE_W-1:0] NO_VALUE  = -32'sd1;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  // codes past the last defined command
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic [LIST_INDEX_W-1:0]   idx;
    logic signed [VALUE_W-1:0] val;
  } list_word_t;

  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    status_t                   status;
    logic [COUNT_OUT_W-1:0]    entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] command = '0;
  logic [LIST_INDEX_W-1:0] list_index = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic done;
  logic signed [VALUE_W-1:0] read_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_OUT_W-1:0] entry_count;

  list_word_t   pending_words[$];
  list_result_t expected_words[$];

  // mirror of the list contents, updated as each command word is taken
  logic signed [VALUE_W-1:0] list_mirror [DEPTH];
  int unsigned mirror_count = 0;

  bit word_taken = 1'b0;
  int sent_words = 0;
  int error_count = 0;
  int stall_cycles = 0;

  indexed_list_engine_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .list_index(list_index),
    .item_value(item_value),
    .done(done),
    .read_value(read_value),
    .status(status),
    .entry_count(entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // apply one command to the mirror and return the word the block should give
  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                      logic [LIST_INDEX_W-1:0] idx,
                                                      logic signed [VALUE_W-1:0] val);
    list_result_t res;
    int unsigned  pos;
    bit           do_insert;
    res.read_value = NO_VALUE;
    res.status     = ST_DONE;
    do_insert      = 1'b0;
    pos            = 0;
    case (cmd)
      CMD_READ: begin
        if (idx < mirror_count) res.read_value = list_mirror[idx];
        else res.status = ST_BAD_POS;
      end
      CMD_HEAD, CMD_TAIL: begin
        if (mirror_count >= DEPTH) res.status = ST_FULL;
        else begin
          do_insert = 1'b1;
          pos = (cmd == CMD_HEAD) ? 0 : mirror_count;
        end
      end
      CMD_AT: begin
        // position check wins over the full check
        if (idx > mirror_count) res.status = ST_BAD_POS;
        else if (mirror_count >= DEPTH) res.status = ST_FULL;
        else begin
          do_insert = 1'b1;
          pos = idx;
        end
      end
      CMD_DELETE: begin
        if (idx < mirror_count) begin
          for (int unsigned i = idx; i + 1 < mirror_count; i++)
            list_mirror[i] = list_mirror[i + 1];
          mirror_count--;
        end else res.status = ST_BAD_POS;
      end
      default: res.status = ST_BAD_POS;
    endcase
    if (do_insert) begin
      for (int unsigned i = mirror_count; i > pos; i--)
        list_mirror[i] = list_mirror[i - 1];
      list_mirror[pos] = val;
      mirror_count++;
    end
    res.entry_count = mirror_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic add_word(logic [CMD_W-1:0] cmd, logic [LIST_INDEX_W-1:0] idx,
                          logic signed [VALUE_W-1:0] val);
    list_word_t w;
    w.cmd = cmd;
    w.idx = idx;
    w.val = val;
    pending_words.push_back(w);
  endtask

  // mostly plain random words, with the sign, zero and all-ones corners mixed in
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2: return NO_VALUE;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // driver: a new word goes out only once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (sent_words % DRAIN_EVERY == DRAIN_AT && expected_words.size() != 0) begin
        // hold off until the block has returned everything in flight
        start <= 1'b0;
      end else if (!(sent_words >= QUIET_FIRST && sent_words < QUIET_LAST) &&
                   $urandom_range(0, 99) < 25) begin
        // random idle cycle, with junk on the command fields
        start      <= 1'b0;
        command    <= CMD_W'($urandom);
        list_index <= LIST_INDEX_W'($urandom);
        item_value <= $urandom;
      end else begin
        start      <= 1'b1;
        command    <= pending_words[0].cmd;
        list_index <= pending_words[0].idx;
        item_value <= pending_words[0].val;
        void'(pending_words.pop_front());
        sent_words <= sent_words + 1;
      end
    end
  end

  // monitor: check done words, predict for taken words, watch for a hang
  always @(posedge clk) begin
    list_result_t exp_word;
    if (rst) begin
      word_taken   = 1'b0;
      stall_cycles = 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, read_value %0d status %0d count %0d",
                   $time, read_value, status, entry_count);
          error_count++;
        end else begin
          exp_word = expected_words.pop_front();
          if (read_value !== exp_word.read_value) begin
            $display("%0t: read_value mismatch, expected %0d actual %0d",
                     $time, exp_word.read_value, read_value);
            error_count++;
          end
          if (status !== exp_word.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, exp_word.status, status);
            error_count++;
          end
          if (entry_count !== exp_word.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d actual %0d",
                     $time, exp_word.entry_count, entry_count);
            error_count++;
          end
        end
      end
      word_taken = start && !busy;
      if (word_taken)
        expected_words.push_back(apply_list_command(command, list_index, item_value));
      if (word_taken || done) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned gen_count;
    int unsigned pick;
    int unsigned r;
    bit          filling;
    logic [CMD_W-1:0] cmd;
    logic [LIST_INDEX_W-1:0] idx;

    // directed: empty list, edges of position, value extremes, odd codes
    add_word(CMD_READ, 0, pick_value());
    add_word(CMD_DELETE, 0, pick_value());
    add_word(CMD_AT, 1, VALUE_MAX);          // past the count on an empty list
    add_word(CMD_AT, 0, '0);                 // at the count: append
    add_word(CMD_HEAD, 0, VALUE_MIN);
    add_word(CMD_TAIL, 1023, VALUE_MAX);
    add_word(CMD_AT, 3, 32'sh5a5a_a5a5);     // at the count again
    add_word(CMD_AT, 1, NO_VALUE);
    add_word(CMD_READ, 0, '0);
    add_word(CMD_READ, 1, '0);
    add_word(CMD_READ, 4, '0);
    add_word(CMD_READ, 5, '0);               // read past the end
    add_word(CMD_READ, 1023, '0);
    add_word(CMD_DELETE, 1023, '0);
    add_word(CMD_AT, 1023, 32'sh1234_5678);
    add_word(CMD_UNUSED_LO, 0, 32'sh0f0f_0f0f);
    add_word(CMD_UNUSED_MID, 1, 32'sh7070_7070);
    add_word(CMD_UNUSED_HI, 1023, NO_VALUE);
    add_word(CMD_DELETE, 4, '0);             // the tail
    add_word(CMD_DELETE, 0, '0);             // the head
    add_word(CMD_READ, 2, '0);
    add_word(CMD_READ, 0, '0);
    gen_count = 3;

    // random: alternate fill and drain phases so the list swings between
    // full and empty, with most positions inside or right at the count
    for (int n = 0; n < NUM_RANDOM; n++) begin
      filling = ((n / 60) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (pick >= 97) cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else if (filling) begin
        if (pick < 15) cmd = CMD_READ;
        else if (pick < 35) cmd = CMD_HEAD;
        else if (pick < 55) cmd = CMD_TAIL;
        else if (pick < 85) cmd = CMD_AT;
        else cmd = CMD_DELETE;
      end else begin
        if (pick < 20) cmd = CMD_READ;
        else if (pick < 28) cmd = CMD_HEAD;
        else if (pick < 36) cmd = CMD_TAIL;
        else if (pick < 46) cmd = CMD_AT;
        else cmd = CMD_DELETE;
      end
      r = $urandom_range(0, 99);
      if (r < 5) idx = LIST_INDEX_W'($urandom_range(0, 1023));
      else if (r < 20) idx = LIST_INDEX_W'(gen_count + $urandom_range(0, 2));
      else idx = LIST_INDEX_W'($urandom_range(0, gen_count));
      add_word(cmd, idx, pick_value());
      // rough track of the count so positions stay mostly valid
      case (cmd)
        CMD_HEAD, CMD_TAIL: if (gen_count < DEPTH) gen_count++;
        CMD_AT: if (idx <= gen_count && gen_count < DEPTH) gen_count++;
        CMD_DELETE: if (idx < gen_count) gen_count--;
        default: ;
      endcase
    end

    // reset released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all words out, then every result back, then the verdict
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
